[sv/rrld_pkg.sv]
// ----------------------------------------------------------------------------
// rrld_pkg
// Shared widths, register map, configuration struct and the level-code lookup
// for the raster run-length decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package rrld_pkg;

  localparam int unsigned GRID_W     = 11;   // grid_size register width
  localparam int unsigned COORD_W    = 10;   // column / row output width
  localparam int unsigned RUN_W      = 4;    // run length nibble
  localparam int unsigned CODE_W     = 4;    // level code nibble
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned CFG_ADDR_W = 5;    // three registers at 8-byte spacing
  localparam int unsigned REG_IDX_W  = 2;

  localparam int unsigned MAX_GRID_DEF = 1024;
  localparam int unsigned GRID_REG_MAX = (1 << GRID_W) - 1;

  localparam logic [GRID_W-1:0] GRID_SIZE_RST = GRID_W'(464);

  typedef enum logic [REG_IDX_W-1:0] {
    REG_GRID_SIZE  = 2'd0,
    REG_TABLE_LOW  = 2'd1,
    REG_TABLE_HIGH = 2'd2,
    REG_UNUSED     = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [GRID_W-1:0]     grid_size;
    logic [CFG_DATA_W-1:0] table_low;
    logic [CFG_DATA_W-1:0] table_high;
  } cfg_t;

  // Code 0..7 from the low word, 8..15 from the high word, one byte each.
  function automatic logic [BYTE_W-1:0] map_code(input cfg_t cfg,
                                                 input logic [CODE_W-1:0] code);
    logic [CFG_DATA_W-1:0] word;
    word = code[CODE_W-1] ? cfg.table_high : cfg.table_low;
    return word[{code[CODE_W-2:0], 3'b000} +: BYTE_W];
  endfunction

endpackage

`default_nettype wire

[sv/rrld_cfg.sv]
// ----------------------------------------------------------------------------
// rrld_cfg
// APB-style register file: grid size and the two level-code table words.
// ----------------------------------------------------------------------------
`default_nettype none

module rrld_cfg
  import rrld_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic      [CFG_DATA_W-1:0] prdata,
  output logic                       pready,
  output cfg_t                       cfg
);

  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[CFG_ADDR_W-1 -: REG_IDX_W]);
  assign wr_en  = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.grid_size  <= GRID_SIZE_RST;
      cfg.table_low  <= '0;
      cfg.table_high <= '0;
    end else if (wr_en) begin
      unique case (idx)
        REG_GRID_SIZE:  cfg.grid_size  <= pwdata[GRID_W-1:0];
        REG_TABLE_LOW:  cfg.table_low  <= pwdata;
        REG_TABLE_HIGH: cfg.table_high <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_GRID_SIZE:  prdata = CFG_DATA_W'(cfg.grid_size);
      REG_TABLE_LOW:  prdata = cfg.table_low;
      REG_TABLE_HIGH: prdata = cfg.table_high;
      default:        prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

[sv/rrld_seq.sv]
// ----------------------------------------------------------------------------
// rrld_seq
// Run sequencer: checks each run byte against the grid, then steps a shared
// column adder once per cell into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rrld_seq
  import rrld_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic [GRID_W-1:0]  size,
  input  wire logic [BYTE_W-1:0]  mapped,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [BYTE_W-1:0]  run_byte,
  input  wire logic               last_in_row,
  input  wire logic               image_start,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [BYTE_W-1:0]       pixel_value,
  output logic [COORD_W-1:0]      column,
  output logic [COORD_W-1:0]      row,
  output logic                    last_of_run,
  output logic                    error
);

  typedef enum logic {IDLE, RUN} state_t;

  state_t              state;
  logic [GRID_W-1:0]   column_count;
  logic [GRID_W-1:0]   row_index;
  logic                error_sticky;
  logic [GRID_W-1:0]   cur_col;
  logic [RUN_W-1:0]    remain;
  logic [BYTE_W-1:0]   cur_val;
  logic [COORD_W-1:0]  cur_row;
  logic                cur_err;

  logic [GRID_W-1:0]   col0;
  logic [GRID_W-1:0]   row0;
  logic                err0;
  logic [RUN_W-1:0]    run_len;
  logic                accept;
  logic                load;
  logic [GRID_W-1:0]   add_a;
  logic [GRID_W-1:0]   add_b;
  logic [GRID_W:0]     sum;
  logic                overflow;
  logic [GRID_W-1:0]   frow;

  assign in_ready = (state == IDLE);
  assign accept   = in_valid && in_ready;
  assign load     = (state == RUN) && (!out_valid || out_ready);

  // image_start clears the running state before this byte is looked at
  assign col0    = image_start ? '0 : column_count;
  assign row0    = image_start ? '0 : row_index;
  assign err0    = image_start ? 1'b0 : error_sticky;
  assign run_len = run_byte[BYTE_W-1 -: RUN_W];

  // Shared adder: end-of-run check while idle, column step while running
  assign add_a    = (state == IDLE) ? col0 : cur_col;
  assign add_b    = (state == IDLE) ? GRID_W'(run_len) : GRID_W'(1);
  assign sum      = {1'b0, add_a} + {1'b0, add_b};
  assign overflow = (row0 >= size) || (sum > {1'b0, size});
  assign frow     = size - GRID_W'(1) - row0;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= IDLE;
      column_count <= '0;
      row_index    <= '0;
      error_sticky <= 1'b0;
      out_valid    <= 1'b0;
      remain       <= '0;
    end else begin
      if (out_ready && !load) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (accept && !err0) begin
            if (overflow) begin
              error_sticky <= 1'b1;
              column_count <= col0;
              row_index    <= row0;
              cur_err      <= 1'b1;
              remain       <= RUN_W'(1);
              state        <= RUN;
            end else begin
              error_sticky <= 1'b0;
              column_count <= last_in_row ? '0 : sum[GRID_W-1:0];
              row_index    <= last_in_row ? row0 + GRID_W'(1) : row0;
              cur_err      <= 1'b0;
              cur_col      <= col0;
              cur_val      <= mapped;
              cur_row      <= frow[COORD_W-1:0];
              remain       <= run_len;
              if (run_len != '0) begin
                state <= RUN;
              end
            end
          end else if (accept) begin
            // dropping until the next image start
          end
        end
        RUN: begin
          if (load) begin
            out_valid   <= 1'b1;
            pixel_value <= cur_err ? '0 : cur_val;
            column      <= cur_err ? '0 : cur_col[COORD_W-1:0];
            row         <= cur_err ? '0 : cur_row;
            last_of_run <= (remain == RUN_W'(1));
            error       <= cur_err;
            cur_col     <= sum[GRID_W-1:0];
            remain      <= remain - RUN_W'(1);
            if (remain == RUN_W'(1)) begin
              state <= IDLE;
            end
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_run_has_cells: assert property (@(posedge clk) disable iff (rst)
    (state == RUN) |-> (remain != '0))
    else $error("sequencer running with no cells left");

  a_error_result_shape: assert property (@(posedge clk) disable iff (rst)
    (out_valid && error) |-> (last_of_run && pixel_value == '0))
    else $error("error result must be a single zero result");

  a_sticky_on_accept: assert property (@(posedge clk) disable iff (rst)
    $rose(error_sticky) |-> $past(in_valid && in_ready))
    else $error("error state set without an accepted transaction");

  a_busy_not_ready: assert property (@(posedge clk) disable iff (rst)
    load |-> !in_ready)
    else $error("input taken while a run is being expanded");
`endif

endmodule

`default_nettype wire

[sv/raster_run_length_decoder_top.sv]
// ----------------------------------------------------------------------------
// raster_run_length_decoder_top
// Expands nibble run bytes of a square raster into mapped cells with column
// and vertically flipped row.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) takes one run byte per transaction with
//   last_in_row and image_start. Output channel (out_valid/out_ready) gives
//   one transaction per covered cell, or a single error transaction when a run
//   passes the grid width or the rows are exhausted; input is then dropped
//   until a byte with image_start. Cells not covered are never emitted.
//   Registers (APB, 64-bit data): 0x00 grid_size, 0x08 level table codes 0-7,
//   0x10 level table codes 8-15. Write them only while the block is idle.
//   Sequencing: a byte is checked on the shared column adder when accepted and
//   its run state registered; the run then steps one cell per cycle into the
//   output register while the receiver is ready. Zero-length and dropped bytes
//   start no run, an error byte a single error result. in_ready is low during a run.
//   A stalled receiver holds the output register and pauses the cell stepping.
//   Reset clears row, column and error state, grid_size returns to 464 and
//   both table words to zero.
// ----------------------------------------------------------------------------
`default_nettype none

module raster_run_length_decoder_top
  import rrld_pkg::*;
#(
  parameter int unsigned MAX_GRID = MAX_GRID_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic      [CFG_DATA_W-1:0] prdata,
  output logic                       pready,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [BYTE_W-1:0]     run_byte,
  input  wire logic                  last_in_row,
  input  wire logic                  image_start,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [BYTE_W-1:0]          pixel_value,
  output logic [COORD_W-1:0]         column,
  output logic [COORD_W-1:0]         row,
  output logic                       last_of_run,
  output logic                       error
);

  localparam int unsigned MAX_EFF = (MAX_GRID < GRID_REG_MAX) ? MAX_GRID : GRID_REG_MAX;
  localparam logic [GRID_W-1:0] MAX_EFF_V = GRID_W'(MAX_EFF);

  cfg_t              cfg;
  logic [GRID_W-1:0] size;
  logic [BYTE_W-1:0] mapped;

  rrld_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // grid size clamped to 1..MAX_GRID
  always_comb begin
    priority if (cfg.grid_size == '0) begin
      size = GRID_W'(1);
    end else if (cfg.grid_size > MAX_EFF_V) begin
      size = MAX_EFF_V;
    end else begin
      size = cfg.grid_size;
    end
  end

  assign mapped = map_code(cfg, run_byte[CODE_W-1:0]);

  rrld_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .size        (size),
    .mapped      (mapped),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .run_byte    (run_byte),
    .last_in_row (last_in_row),
    .image_start (image_start),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .pixel_value (pixel_value),
    .column      (column),
    .row         (row),
    .last_of_run (last_of_run),
    .error       (error)
  );

endmodule

`default_nettype wire
